// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define LIS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define LIS_NEVER(lbl, clk, rstn, expr, msg) \
  `LIS_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

// File: sv/lis_pkg.sv
// Shared types for the longest increasing subsequence block.
// No dependencies; used by scoped names from every RTL file.
package lis_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_TRACE_RD,
    ST_TRACE_WR,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: sv/lis_store.sv
// Element store: value memory plus link memory (chain length, predecessor).
// One write and one read port each, registered read data. Uses lis_pkg.
module lis_store #(
  parameter int VALUE_BITS = 32,
  parameter int IW         = 6,
  parameter int CW         = 7
) (
  input  logic                  clk_i,
  input  lis_pkg::mem_ctl_t     ctl_i,
  input  logic [IW-1:0]         rd_addr_i,
  input  logic [IW-1:0]         wr_addr_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic [CW-1:0]         wr_len_i,
  input  logic [IW-1:0]         wr_pred_i,
  output logic [VALUE_BITS-1:0] rd_value_o,
  output logic [CW-1:0]         rd_len_o,
  output logic [IW-1:0]         rd_pred_o
);

  localparam int Depth = 2 ** IW;

  logic [VALUE_BITS-1:0] value_mem [Depth];
  logic [CW+IW-1:0]      link_mem  [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      value_mem[wr_addr_i] <= wr_value_i;
      link_mem[wr_addr_i]  <= {wr_len_i, wr_pred_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_value_o            <= value_mem[rd_addr_i];
      {rd_len_o, rd_pred_o} <= link_mem[rd_addr_i];
    end
  end

endmodule

// File: sv/lis_trace_buf.sv
// Trace buffer: chain values written back to front, read front to back.
// One write and one read port, registered read data. Uses lis_pkg.
module lis_trace_buf #(
  parameter int VALUE_BITS = 32,
  parameter int IW         = 6
) (
  input  logic                  clk_i,
  input  lis_pkg::mem_ctl_t     ctl_i,
  input  logic [IW-1:0]         wr_addr_i,
  input  logic [VALUE_BITS-1:0] wr_data_i,
  input  logic [IW-1:0]         rd_addr_i,
  output logic [VALUE_BITS-1:0] rd_data_o
);

  localparam int Depth = 2 ** IW;

  logic [VALUE_BITS-1:0] buf_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      buf_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_o <= buf_mem[rd_addr_i];
    end
  end

endmodule

// File: sv/longest_increasing_subsequence.sv
// Longest strictly increasing subsequence, quadratic DP over a memory store.
// Store: busy covers the store reads, a compare of the last read, a drain step and a
//   write-back (only those two when empty); a dropped item without end mark leaves busy low.
// End mark: trace-back, then emit; each result shows in the cycle after its buffer read.
// Reset clears counters and control; memories are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module longest_increasing_subsequence #(
  parameter int MAX_ITEMS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] sample_value_i,
  input  logic                         end_of_sequence_i,
  output logic                         chain_valid_o,
  output logic signed [VALUE_BITS-1:0] chain_value_o,
  output logic                         chain_last_o,
  output logic                         truncated_o
);

  // Index width addresses the store; count width also holds MAX_ITEMS itself.
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  lis_pkg::state_e state_q, state_d;

  // Control state
  logic [CW-1:0] count_q, count_d;      // stored elements
  logic          ovf_q, ovf_d;          // element dropped this sequence
  logic [CW-1:0] max_len_q, max_len_d;  // best chain length so far
  logic [IW-1:0] end_q, end_d;          // first position holding max_len
  logic [CW-1:0] scan_q, scan_d;        // next store address to read in scan
  logic          pend_q, pend_d;        // store read data arrives this cycle
  logic [CW-1:0] k_q, k_d;              // trace-back: chain slots left
  logic [IW-1:0] emit_q, emit_d;        // next trace buffer slot to read
  logic          out_vld_q, out_vld_d;
  logic          out_last_q, out_last_d;
  logic          out_trunc_q, out_trunc_d;

  // Payload
  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic                         last_q, last_d;
  logic [CW-1:0]                best_q, best_d;
  logic [IW-1:0]                from_q, from_d;
  logic [IW-1:0]                pidx_q, pidx_d;
  logic [IW-1:0]                pos_q, pos_d;

  // Memory ports
  lis_pkg::mem_ctl_t     store_ctl;
  logic [IW-1:0]         store_rd_addr;
  logic [VALUE_BITS-1:0] store_rd_value;
  logic [CW-1:0]         store_rd_len;
  logic [IW-1:0]         store_rd_pred;
  lis_pkg::mem_ctl_t     trace_ctl;
  logic [VALUE_BITS-1:0] trace_rd_data;

  logic [CW-1:0] len_plus;
  logic          is_less;
  logic [CW-1:0] k_m1;

  assign len_plus = store_rd_len + CW'(1);
  assign is_less  = $signed(store_rd_value) < val_q;
  assign k_m1     = k_q - CW'(1);

  lis_store #(
    .VALUE_BITS(VALUE_BITS),
    .IW        (IW),
    .CW        (CW)
  ) u_store (
    .clk_i     (clk_i),
    .ctl_i     (store_ctl),
    .rd_addr_i (store_rd_addr),
    .wr_addr_i (count_q[IW-1:0]),
    .wr_value_i(val_q),
    .wr_len_i  (best_q),
    .wr_pred_i (from_q),
    .rd_value_o(store_rd_value),
    .rd_len_o  (store_rd_len),
    .rd_pred_o (store_rd_pred)
  );

  lis_trace_buf #(
    .VALUE_BITS(VALUE_BITS),
    .IW        (IW)
  ) u_trace (
    .clk_i    (clk_i),
    .ctl_i    (trace_ctl),
    .wr_addr_i(k_m1[IW-1:0]),
    .wr_data_i(store_rd_value),
    .rd_addr_i(emit_q),
    .rd_data_o(trace_rd_data)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ovf_d         = ovf_q;
    max_len_d     = max_len_q;
    end_d         = end_q;
    scan_d        = scan_q;
    pend_d        = 1'b0;
    k_d           = k_q;
    emit_d        = emit_q;
    out_vld_d     = 1'b0;
    out_last_d    = 1'b0;
    out_trunc_d   = out_trunc_q;
    val_d         = val_q;
    last_d        = last_q;
    best_d        = best_q;
    from_d        = from_q;
    pidx_d        = pidx_q;
    pos_d         = pos_q;
    store_ctl     = '0;
    store_rd_addr = scan_q[IW-1:0];
    trace_ctl     = '0;

    unique case (state_q)
      lis_pkg::ST_IDLE: begin
        if (start) begin
          // Take the transfer; a chain of one is the starting point.
          val_d  = sample_value_i;
          last_d = end_of_sequence_i;
          best_d = CW'(1);
          from_d = '0;
          scan_d = '0;
          if (count_q < CW'(MAX_ITEMS)) begin
            state_d = lis_pkg::ST_SCAN;
          end else begin
            // Store full: drop the element, still emit on the end mark.
            ovf_d = 1'b1;
            if (end_of_sequence_i) begin
              k_d     = max_len_q;
              pos_d   = end_q;
              state_d = lis_pkg::ST_TRACE_RD;
            end
          end
        end
      end

      lis_pkg::ST_SCAN: begin
        // Compare the element read last cycle; strict less keeps equals out,
        // strict greater on length keeps the earliest predecessor.
        if (pend_q && is_less && (best_q < len_plus)) begin
          best_d = len_plus;
          from_d = pidx_q;
        end
        if (scan_q < count_q) begin
          store_ctl.rd_en = 1'b1;
          pend_d          = 1'b1;
          pidx_d          = scan_q[IW-1:0];
          scan_d          = scan_q + CW'(1);
        end else if (!pend_q) begin
          state_d = lis_pkg::ST_WRITE;
        end
      end

      lis_pkg::ST_WRITE: begin
        // Write back the new entry and track the first maximum.
        store_ctl.wr_en = 1'b1;
        count_d         = count_q + CW'(1);
        if (best_q > max_len_q) begin
          max_len_d = best_q;
          end_d     = count_q[IW-1:0];
        end
        if (last_q) begin
          k_d     = max_len_d;
          pos_d   = end_d;
          state_d = lis_pkg::ST_TRACE_RD;
        end else begin
          state_d = lis_pkg::ST_IDLE;
        end
      end

      lis_pkg::ST_TRACE_RD: begin
        store_ctl.rd_en = 1'b1;
        store_rd_addr   = pos_q;
        state_d         = lis_pkg::ST_TRACE_WR;
      end

      lis_pkg::ST_TRACE_WR: begin
        // Park the value at its forward slot, follow the predecessor link.
        trace_ctl.wr_en = 1'b1;
        k_d             = k_m1;
        pos_d           = store_rd_pred;
        if (k_q == CW'(1)) begin
          emit_d  = '0;
          state_d = lis_pkg::ST_EMIT;
        end else begin
          state_d = lis_pkg::ST_TRACE_RD;
        end
      end

      lis_pkg::ST_EMIT: begin
        // Stream the buffer out, one result per cycle.
        trace_ctl.rd_en = 1'b1;
        out_vld_d       = 1'b1;
        out_trunc_d     = ovf_q;
        emit_d          = emit_q + IW'(1);
        if (CW'(emit_q) == (max_len_q - CW'(1))) begin
          out_last_d = 1'b1;
          count_d    = '0;
          ovf_d      = 1'b0;
          max_len_d  = '0;
          end_d      = '0;
          state_d    = lis_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lis_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lis_pkg::ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      max_len_q   <= '0;
      end_q       <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      k_q         <= '0;
      emit_q      <= '0;
      out_vld_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_trunc_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      max_len_q   <= max_len_d;
      end_q       <= end_d;
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      k_q         <= k_d;
      emit_q      <= emit_d;
      out_vld_q   <= out_vld_d;
      out_last_q  <= out_last_d;
      out_trunc_q <= out_trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    last_q <= last_d;
    best_q <= best_d;
    from_q <= from_d;
    pidx_q <= pidx_d;
    pos_q  <= pos_d;
  end

  assign busy          = (state_q != lis_pkg::ST_IDLE);
  assign chain_valid_o = out_vld_q;
  assign chain_value_o = $signed(trace_rd_data);
  assign chain_last_o  = out_last_q;
  assign truncated_o   = out_trunc_q;

endmodule

// File: sv/lis_checker.sv
// Port-level checks for the longest increasing subsequence block, bound to
// the top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module lis_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy,
  input logic chain_valid_o,
  input logic chain_last_o,
  input logic truncated_o
);

  // A result burst only follows work in progress.
  `LIS_ASSERT(a_valid_after_busy, clk_i, rst_ni, chain_valid_o |-> $past(busy), "result without prior work")
  // The last marker rides only on a shown result.
  `LIS_NEVER(a_last_needs_valid, clk_i, rst_ni, chain_last_o && !chain_valid_o, "last without strobe")
  // A burst runs without gaps up to its last result.
  `LIS_ASSERT(a_burst_gapless, clk_i, rst_ni, (chain_valid_o && !chain_last_o) |=> chain_valid_o, "gap in result burst")
  // Nothing follows the last result directly.
  `LIS_ASSERT(a_burst_ends, clk_i, rst_ni, (chain_valid_o && chain_last_o) |=> !chain_valid_o, "result after last")
  // The truncation flag is the same on every result of one burst.
  `LIS_ASSERT(a_trunc_steady, clk_i, rst_ni, (chain_valid_o && $past(chain_valid_o) && !$past(chain_last_o)) |-> (truncated_o == $past(truncated_o)), "truncated changed in burst")

endmodule

bind longest_increasing_subsequence lis_checker u_lis_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy         (busy),
  .chain_valid_o(chain_valid_o),
  .chain_last_o (chain_last_o),
  .truncated_o  (truncated_o)
);
